@@ rtl/rrm_pkg.sv @@
// Shared types and constants for the resource race monitor.
// No dependencies; imported by the table, scan and top-level modules.
`timescale 1ns / 1ps

package rrm_pkg;

  localparam int KEY_W   = 48;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(10);

  localparam logic REG_COUNT_LIMIT = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    accessor;
    logic [TIME_W-1:0]  stamp;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic race;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scan_state_t;

endpackage

@@ rtl/rrm_table.sv @@
// Entry table: one synchronous memory, one write and one registered read port.
// Depends on rrm_pkg for the entry layout.
`timescale 1ns / 1ps

module rrm_table
  import rrm_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/rrm_scan.sv @@
// Scan sequencer: walks the table an entry per cycle, updates or appends if room.
// Depends on rrm_pkg; drives the rrm_table ports.
`timescale 1ns / 1ps

module rrm_scan
  import rrm_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [ID_W-1:0]    in_who,
  input  logic [TIME_W-1:0]  in_time,
  input  logic [COUNT_W-1:0] count_limit,
  input  logic               res_ready,
  output result_t            res,
  output mem_ctl_t           mem_ctl,
  output logic [IDX_W-1:0]   rd_addr,
  input  entry_t             rd_data,
  output logic [IDX_W-1:0]   wr_addr,
  output entry_t             wr_data
);

  scan_state_t        state_r, state_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [ID_W-1:0]    who_r;
  logic [TIME_W-1:0]  time_r;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic               race_r, race_nxt;
  logic               hit;
  logic               contended;
  logic [COUNT_W-1:0] count_new;
  logic               race_now;

  assign hit       = pend_r && (rd_data.key == key_r);
  assign contended = (rd_data.accessor != who_r) && (rd_data.stamp == time_r);
  assign count_new = (rd_data.count == COUNT_MAX) ? rd_data.count
                                                  : rd_data.count + COUNT_W'(1);
  assign race_now  = contended && (count_new > count_limit);
  assign in_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      pend_r     <= 1'b0;
      scan_idx_r <= '0;
      race_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      pend_r     <= pend_nxt;
      scan_idx_r <= scan_idx_nxt;
      race_r     <= race_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (in_valid && in_ready) begin
      key_r  <= in_key;
      who_r  <= in_who;
      time_r <= in_time;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    scan_idx_nxt  = scan_idx_r;
    race_nxt      = race_r;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    rd_addr       = scan_idx_r[IDX_W-1:0];
    wr_addr       = pend_idx_r;
    wr_data       = rd_data;
    res.valid     = 1'b0;
    res.race      = race_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          race_nxt     = 1'b0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_ctl.wr_en    = 1'b1;
          wr_data.key      = key_r;
          wr_data.accessor = race_now ? rd_data.accessor : who_r;
          wr_data.stamp    = race_now ? rd_data.stamp : time_r;
          wr_data.count    = contended ? count_new : rd_data.count;
          race_nxt         = race_now;
          state_nxt        = S_DONE;
        end else if (!pend_r && (scan_idx_r >= used_r)) begin
          if (used_r < CNT_W'(DEPTH)) begin
            mem_ctl.wr_en    = 1'b1;
            wr_addr          = used_r[IDX_W-1:0];
            wr_data.key      = key_r;
            wr_data.accessor = who_r;
            wr_data.stamp    = time_r;
            wr_data.count    = COUNT_FIRST;
            used_nxt         = used_r + CNT_W'(1);
          end
          race_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (scan_idx_r < used_r) begin
          mem_ctl.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          pend_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("table fill count beyond depth");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (CNT_W'(pend_idx_r) < used_r))
    else $error("pending read beyond filled entries");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (used_r == $past(used_r) || used_r == $past(used_r) + CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> !mem_ctl.wr_en)
    else $error("table write outside scan");
`endif

endmodule

@@ rtl/resource_race_monitor.sv @@
// Resource race monitor: the top level with APB register, output register and table.
// Depends on rrm_pkg, rrm_scan and rrm_table.
`timescale 1ns / 1ps

// Each accepted word is looked up by a linear scan of the entry table, which sits in
// one single-port-read memory and is read one entry per cycle. The scan reads every
// filled entry (at most TABLE_DEPTH) for a word that misses and stops at the entry
// that a hit finds; the result then waits in S_DONE until the output register can
// take it. The scanner returns to idle as the result is registered and only then
// accepts the next word. A hit or an append is written back in the cycle that
// finishes the scan. A new word is taken while the previous result still waits in
// the output register. count_limit lies at byte address 0.

module resource_race_monitor
  import rrm_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEY_W-1:0]   in_resource_key,
  input  logic [ID_W-1:0]    in_accessor_id,
  input  logic [TIME_W-1:0]  in_time_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_race_suspected,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0] count_limit_r;
  logic               out_valid_r;
  logic               out_race_r;
  logic               res_ready;
  result_t            res;
  mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             rd_data;
  entry_t             wr_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_COUNT_LIMIT) ? DATA_W'(count_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_COUNT_LIMIT)) begin
      count_limit_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_race_r <= res.race;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_race_suspected = out_race_r;

  rrm_scan #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_key      (in_resource_key),
    .in_who      (in_accessor_id),
    .in_time     (in_time_seconds),
    .count_limit (count_limit_r),
    .res_ready   (res_ready),
    .res         (res),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  rrm_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
